FILE: design/afr_pkg.sv
package afr_pkg;

    // frame layout
    localparam int FRAME_BYTES = 12;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_CH0_FIRST = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CH0_LAST  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_CH1_LAST  = POS_W'(8);

    // sample scaling
    localparam int SAMPLE_W    = 24;
    localparam int SCALE_W     = 15;
    localparam logic [SCALE_W-1:0] TRAVEL_SCALE = SCALE_W'(27548);
    localparam int SCALE_SHIFT = 23;
    localparam int PROD_W      = (SAMPLE_W - 1) + SCALE_W;
    localparam int VAL_W       = 16;
    localparam logic [VAL_W-1:0] POS_MAX = 16'hfffe;
    localparam logic [VAL_W-1:0] RECORD_LENGTH_RESET = 16'd1024;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECORDING_ENABLE = 4'd0,
        CFG_RECORD_LENGTH    = 4'd1,
        CFG_FORK_BASELINE    = 4'd2,
        CFG_SHOCK_BASELINE   = 4'd3
    } t_cfg_index;

    typedef struct packed {
        logic             recording_enable;
        logic [VAL_W-1:0] record_length;
        logic [VAL_W-1:0] fork_baseline;
        logic [VAL_W-1:0] shock_baseline;
    } t_cfg;

    // raw channel pair of one completed frame
    typedef struct packed {
        logic [SAMPLE_W-1:0] ch0;
        logic [SAMPLE_W-1:0] ch1;
    } t_frame;

    // queue handshake seen by the front
    typedef struct packed {
        logic   push;
        t_frame data;
    } t_push;

endpackage

FILE: design/adc_frame_travel_recorder.sv
// channel  direction  handshake                 payload
// ------------------------------------------------------------------------------
// input    in         i_valid / o_ready         i_rx_byte[7:0], i_frame_start
// result   out        o_valid / i_ready         positions, travels, record fields
// config   in         i_cfg_valid / o_cfg_ready i_cfg_index[3:0], i_cfg_data[15:0]
//
// one word is accepted every cycle; a stalled output holds the back end, and
// o_ready drops only on a frame's last word once the two-entry queue is full.
// a result passes from the last word of its frame through the queue, the
// multiplier stage, then the output register.
// reset is synchronous, active low; it clears position, shifter, counter and
// all valid flags, and loads the register defaults.
module adc_frame_travel_recorder
    import afr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_frame_start,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [VAL_W-1:0]     o_fork_position,
    output logic [VAL_W-1:0]     o_shock_position,
    output logic [VAL_W-1:0]     o_fork_travel,
    output logic [VAL_W-1:0]     o_shock_travel,
    output logic                 o_recorded,
    output logic [VAL_W-1:0]     o_record_index,
    output logic                 o_block_full,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    t_cfg   r_cfg;
    t_push  push;
    logic   q_full;
    logic   q_valid;
    t_frame q_data;
    logic   q_pop;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.recording_enable <= 1'b0;
            r_cfg.record_length    <= RECORD_LENGTH_RESET;
            r_cfg.fork_baseline    <= '0;
            r_cfg.shock_baseline   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RECORDING_ENABLE: r_cfg.recording_enable <= i_cfg_data[0];
                CFG_RECORD_LENGTH:    r_cfg.record_length    <= i_cfg_data;
                CFG_FORK_BASELINE:    r_cfg.fork_baseline    <= i_cfg_data;
                CFG_SHOCK_BASELINE:   r_cfg.shock_baseline   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame assembly
    afr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .i_queue_full  (q_full),
        .o_push        (push)
    );

    // frame queue
    afr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    // scaling and recording
    afr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_queue_valid    (q_valid),
        .i_queue_data     (q_data),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_fork_position  (o_fork_position),
        .o_shock_position (o_shock_position),
        .o_fork_travel    (o_fork_travel),
        .o_shock_travel   (o_shock_travel),
        .o_recorded       (o_recorded),
        .o_record_index   (o_record_index),
        .o_block_full     (o_block_full)
    );

endmodule

FILE: design/afr_queue.sv
module afr_queue
    import afr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_full,
    output logic   o_valid,
    output t_frame o_data,
    input  logic   i_pop
);

    t_frame            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

endmodule

FILE: design/afr_front.sv
module afr_front
    import afr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    input  logic       i_queue_full,
    output t_push      o_push
);

    logic [POS_W-1:0]    r_pos, n_pos;
    logic [SAMPLE_W-1:0] r_shift, n_shift;
    logic [SAMPLE_W-1:0] r_ch0, n_ch0;
    logic [POS_W-1:0]    pos;
    logic                is_last;
    logic                accept;

    // resolve position of this word
    assign pos     = i_frame_start ? '0 : r_pos;
    assign is_last = (pos == POS_LAST);
    assign o_ready = !(is_last && i_queue_full);
    assign accept  = i_valid && o_ready;

    // byte assembly
    always_comb begin
        n_pos   = r_pos;
        n_shift = r_shift;
        n_ch0   = r_ch0;
        if (accept) begin
            if (pos >= POS_CH0_FIRST && pos <= POS_CH1_LAST) begin
                n_shift = {r_shift[SAMPLE_W-9:0], i_rx_byte};
            end
            if (pos == POS_CH0_LAST) begin
                n_ch0 = n_shift;
            end
            n_pos = is_last ? '0 : pos + 1'b1;
        end
    end

    assign o_push.push     = accept && is_last;
    assign o_push.data.ch0 = r_ch0;
    assign o_push.data.ch1 = n_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_shift <= '0;
            r_ch0   <= '0;
        end else begin
            r_pos   <= n_pos;
            r_shift <= n_shift;
            r_ch0   <= n_ch0;
        end
    end

endmodule

FILE: design/afr_back.sv
module afr_back
    import afr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_queue_valid,
    input  t_frame           i_queue_data,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [VAL_W-1:0] o_fork_position,
    output logic [VAL_W-1:0] o_shock_position,
    output logic [VAL_W-1:0] o_fork_travel,
    output logic [VAL_W-1:0] o_shock_travel,
    output logic             o_recorded,
    output logic [VAL_W-1:0] o_record_index,
    output logic             o_block_full
);

    logic              r_a_valid;
    logic [PROD_W-1:0] r_a_prod0;
    logic [PROD_W-1:0] r_a_prod1;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_fork_pos, r_shock_pos, r_fork_trv, r_shock_trv;
    logic              r_recorded, r_full;
    logic [VAL_W-1:0]  r_index;
    logic [VAL_W-1:0]  r_counter, n_counter;
    logic              b_load;
    logic              a_load;
    logic [PROD_W-1:0] prod0, prod1;
    logic [VAL_W-1:0]  fpos, spos, ftrv, strv;
    logic [VAL_W-1:0]  cnt_next;
    logic              full_now;

    function automatic logic [PROD_W-1:0] scale_mul(input logic [SAMPLE_W-1:0] raw);
        logic positive;
        positive = (raw != '0) && !raw[SAMPLE_W-1];
        return positive ? (PROD_W'(raw[SAMPLE_W-2:0]) * PROD_W'(TRAVEL_SCALE)) : '0;
    endfunction

    function automatic logic [VAL_W-1:0] scale_sat(input logic [PROD_W-1:0] prod);
        logic [VAL_W-1:0] v;
        v = VAL_W'(prod[PROD_W-1:SCALE_SHIFT]);
        return (v > POS_MAX) ? POS_MAX : v;
    endfunction

    function automatic logic [VAL_W-1:0] remove_base(input logic [VAL_W-1:0] value,
                                                     input logic [VAL_W-1:0] base);
        logic [VAL_W-1:0] d;
        d = value - base;
        if (value <= base) begin
            return '0;
        end
        return (d > POS_MAX) ? POS_MAX : d;
    endfunction

    // stage handshakes
    assign b_load = r_a_valid && (!r_out_valid || i_ready);
    assign a_load = !r_a_valid || b_load;
    assign o_pop  = a_load && i_queue_valid;

    // stage a: multiply
    assign prod0 = scale_mul(i_queue_data.ch0);
    assign prod1 = scale_mul(i_queue_data.ch1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_load) begin
            r_a_valid <= i_queue_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_prod0 <= prod0;
            r_a_prod1 <= prod1;
        end
    end

    // stage b: saturate, baseline, record counter
    assign fpos     = scale_sat(r_a_prod0);
    assign spos     = scale_sat(r_a_prod1);
    assign ftrv     = remove_base(fpos, i_cfg.fork_baseline);
    assign strv     = remove_base(spos, i_cfg.shock_baseline);
    assign cnt_next = r_counter + 1'b1;
    assign full_now = (cnt_next == i_cfg.record_length);

    always_comb begin
        n_counter = r_counter;
        if (b_load && i_cfg.recording_enable) begin
            n_counter = full_now ? '0 : cnt_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_counter   <= '0;
        end else begin
            r_counter <= n_counter;
            if (b_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_fork_pos  <= fpos;
            r_shock_pos <= spos;
            r_fork_trv  <= ftrv;
            r_shock_trv <= strv;
            r_recorded  <= i_cfg.recording_enable;
            r_index     <= i_cfg.recording_enable ? r_counter : '0;
            r_full      <= i_cfg.recording_enable && full_now;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_fork_position  = r_fork_pos;
    assign o_shock_position = r_shock_pos;
    assign o_fork_travel    = r_fork_trv;
    assign o_shock_travel   = r_shock_trv;
    assign o_recorded       = r_recorded;
    assign o_record_index   = r_index;
    assign o_block_full     = r_full;

endmodule

FILE: design/afr_checker.sv
module afr_checker
    import afr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_valid,
    input  logic                 i_ready,
    input  logic [VAL_W-1:0]     o_fork_position,
    input  logic [VAL_W-1:0]     o_shock_position,
    input  logic [VAL_W-1:0]     o_fork_travel,
    input  logic [VAL_W-1:0]     o_shock_travel,
    input  logic                 o_recorded,
    input  logic [VAL_W-1:0]     o_record_index,
    input  logic                 o_block_full
);

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_fork_position)
            && $stable(o_shock_travel) && $stable(o_record_index))
        else $error("result changed while stalled");

    // no record fields unless recorded
    a_unrecorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_recorded |-> o_record_index == '0 && !o_block_full)
        else $error("record fields set on unrecorded frame");

    // travel never exceeds position
    a_fork_travel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fork_travel <= o_fork_position && o_fork_position <= POS_MAX)
        else $error("fork travel above position");

    a_shock_travel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_shock_travel <= o_shock_position && o_shock_position <= POS_MAX)
        else $error("shock travel above position");

endmodule

bind adc_frame_travel_recorder afr_checker u_afr_checker (.*);
